[hdl/assert_macros.svh]
// Assertion helpers shared by the transcoder modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

[hdl/utx_pkg.sv]
package utx_pkg;

	localparam int UNIT_W = 16;
	localparam int CP_W = 22;
	localparam int CNT_W = 3;
	localparam int QUEUE_DEPTH_DEF = 4;

	localparam logic [UNIT_W-1:0] SURR_FIRST = 16'hD800;
	localparam logic [UNIT_W-1:0] SURR_LAST = 16'hDFFF;
	localparam logic [UNIT_W-1:0] SURR_HIGH_BASE = 16'hD800;
	localparam logic [UNIT_W-1:0] SURR_LOW_BASE = 16'hDC00;
	localparam logic [CP_W-1:0] SUPP_BASE = 22'h010000;
	localparam logic [CP_W-1:0] ONE_BYTE_MAX = 22'h00007F;
	localparam logic [CP_W-1:0] TWO_BYTE_MAX = 22'h0007FF;
	localparam logic [CP_W-1:0] BMP_MAX = 22'h00FFFF;

	typedef enum logic [1:0] {
		KIND_EOS,
		KIND_TO_UTF16,
		KIND_TO_UTF8
	} emit_kind_t;

	typedef struct packed {
		emit_kind_t kind;
		logic [CP_W-1:0] code_point;
	} utx_entry_t;

endpackage

[hdl/utf8_utf16_transcoder_top.sv]
// Channel    | Handshake            | Beat contents
// input      | push / full          | code_unit
// result     | pop / empty          | out_unit, last_of_run, end_of_string
// config     | cfg_valid / cfg_ready| cfg_data (direction)
//
// An input unit is taken every cycle while the result queue has room.
// A completed code point gives one to four result beats, one per cycle while popped.
// A unit's first result shows once its entry is written and reaches the queue head.
// The queue holds QUEUE_DEPTH entries, so input stalls only when it is full.
// Reset is asynchronous and selects UTF-8 to UTF-16 with no sequence in progress.

module utf8_utf16_transcoder_top import utx_pkg::*; #(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic cfg_data,
	input  logic push,
	output logic full,
	input  logic [UNIT_W-1:0] code_unit,
	input  logic pop,
	output logic empty,
	output logic [UNIT_W-1:0] out_unit,
	output logic last_of_run,
	output logic end_of_string
);

	logic q_push;
	utx_entry_t q_push_entry;
	logic q_full;
	logic q_pop;
	utx_entry_t q_head;
	logic q_empty;

	assign cfg_ready = 1'b1;
	assign full = q_full;

	utx_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.push         (push),
		.code_unit    (code_unit),
		.q_full       (q_full),
		.q_push       (q_push),
		.q_push_entry (q_push_entry)
	);

	utx_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_push       (q_push),
		.q_push_entry (q_push_entry),
		.q_full       (q_full),
		.q_pop        (q_pop),
		.q_head       (q_head),
		.q_empty      (q_empty)
	);

	utx_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_head        (q_head),
		.q_empty       (q_empty),
		.q_pop         (q_pop),
		.pop           (pop),
		.empty         (empty),
		.out_unit      (out_unit),
		.last_of_run   (last_of_run),
		.end_of_string (end_of_string)
	);

endmodule

[hdl/utx_queue.sv]
`include "assert_macros.svh"

module utx_queue import utx_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic q_push,
	input  utx_entry_t q_push_entry,
	output logic q_full,
	input  logic q_pop,
	output utx_entry_t q_head,
	output logic q_empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	utx_entry_t entry_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign q_full = (count_q == CW'(DEPTH));
	assign q_empty = (count_q == '0);
	assign q_head = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (q_push) begin
			entry_q[wr_ptr_q] <= q_push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (q_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (q_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			if (q_push && !q_pop) begin
				count_q <= count_q + CW'(1);
			end else if (q_pop && !q_push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	`ASSERT_IMPLIES(a_count_bound, clk, arst_n, 1'b1, count_q <= CW'(DEPTH))
	`ASSERT_IMPLIES(a_no_overflow, clk, arst_n, q_full, !q_push)
	`ASSERT_IMPLIES(a_no_underflow, clk, arst_n, q_empty, !q_pop)

endmodule

[hdl/utx_front.sv]
`include "assert_macros.svh"

module utx_front import utx_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_valid,
	input  logic cfg_ready,
	input  logic cfg_data,
	input  logic push,
	input  logic [UNIT_W-1:0] code_unit,
	input  logic q_full,
	output logic q_push,
	output utx_entry_t q_push_entry
);

	logic direction_q;
	logic [CP_W-1:0] acc_q;
	logic [CNT_W-1:0] expected_q;
	logic [CNT_W-1:0] seen_q;

	logic [CP_W-1:0] acc_d;
	logic [CNT_W-1:0] expected_d;
	logic [CNT_W-1:0] seen_d;
	logic emit;
	utx_entry_t entry;

	logic accept;
	logic cfg_write;
	logic [7:0] byte_in;
	logic [CNT_W-1:0] seen_inc;
	logic [CP_W-1:0] acc_shift;
	logic [20:0] pair_cp;

	assign accept = push && !q_full;
	assign cfg_write = cfg_valid && cfg_ready;
	assign byte_in = code_unit[7:0];
	assign seen_inc = seen_q + CNT_W'(1);
	assign acc_shift = {acc_q[CP_W-7:0], byte_in[5:0]};
	assign pair_cp = 21'({acc_q[9:0], code_unit[9:0]}) + 21'(SUPP_BASE);

	always_comb begin
		acc_d = acc_q;
		expected_d = expected_q;
		seen_d = seen_q;
		emit = 1'b0;
		entry.kind = KIND_EOS;
		entry.code_point = '0;
		if (!direction_q) begin
			if (expected_q == '0) begin
				priority if (byte_in == 8'h00) begin
					emit = 1'b1;
					entry.kind = KIND_EOS;
				end else if (!byte_in[7]) begin
					emit = 1'b1;
					entry.kind = KIND_TO_UTF16;
					entry.code_point = CP_W'(byte_in);
				end else if (!byte_in[5]) begin
					expected_d = CNT_W'(2);
					acc_d = CP_W'(byte_in[5:0]);
					seen_d = CNT_W'(1);
				end else if (!byte_in[4]) begin
					expected_d = CNT_W'(3);
					acc_d = CP_W'(byte_in[4:0]);
					seen_d = CNT_W'(1);
				end else begin
					expected_d = CNT_W'(4);
					acc_d = CP_W'(byte_in[3:0]);
					seen_d = CNT_W'(1);
				end
			end else begin
				acc_d = acc_shift;
				seen_d = seen_inc;
				if (seen_inc >= expected_q) begin
					emit = 1'b1;
					entry.kind = KIND_TO_UTF16;
					entry.code_point = acc_shift;
					acc_d = '0;
					expected_d = '0;
					seen_d = '0;
				end
			end
		end else begin
			if (expected_q == '0) begin
				priority if (code_unit == '0) begin
					emit = 1'b1;
					entry.kind = KIND_EOS;
				end else if (code_unit >= SURR_FIRST && code_unit <= SURR_LAST) begin
					acc_d = CP_W'(code_unit);
					expected_d = CNT_W'(2);
					seen_d = CNT_W'(1);
				end else begin
					emit = 1'b1;
					entry.kind = KIND_TO_UTF8;
					entry.code_point = CP_W'(code_unit);
				end
			end else begin
				emit = 1'b1;
				entry.kind = KIND_TO_UTF8;
				entry.code_point = CP_W'(pair_cp);
				acc_d = '0;
				expected_d = '0;
				seen_d = '0;
			end
		end
	end

	assign q_push = accept && emit;
	assign q_push_entry = entry;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			direction_q <= 1'b0;
			acc_q <= '0;
			expected_q <= '0;
			seen_q <= '0;
		end else if (cfg_write) begin
			direction_q <= cfg_data;
			acc_q <= '0;
			expected_q <= '0;
			seen_q <= '0;
		end else if (accept) begin
			acc_q <= acc_d;
			expected_q <= expected_d;
			seen_q <= seen_d;
		end
	end

	`ASSERT_NEXT(a_cfg_clears_seq, clk, arst_n, cfg_write, expected_q == '0 && seen_q == '0)
	`ASSERT_IMPLIES(a_seen_bound, clk, arst_n, 1'b1, seen_q <= expected_q)
	`ASSERT_IMPLIES(a_pair_len, clk, arst_n, direction_q && expected_q != '0,
		expected_q == CNT_W'(2) && seen_q == CNT_W'(1))

endmodule

[hdl/utx_back.sv]
`include "assert_macros.svh"

module utx_back import utx_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  utx_entry_t q_head,
	input  logic q_empty,
	output logic q_pop,
	input  logic pop,
	output logic empty,
	output logic [UNIT_W-1:0] out_unit,
	output logic last_of_run,
	output logic end_of_string
);

	logic [1:0] idx_q;
	logic [1:0] last_idx;
	logic [UNIT_W-1:0] unit0;
	logic [UNIT_W-1:0] unit1;
	logic [UNIT_W-1:0] unit2;
	logic [UNIT_W-1:0] unit3;
	logic is_eos;
	logic [CP_W-1:0] cp;
	logic [CP_W-1:0] supp_off;
	logic beat;

	assign cp = q_head.code_point;
	assign supp_off = cp - SUPP_BASE;

	always_comb begin
		unit0 = '0;
		unit1 = '0;
		unit2 = '0;
		unit3 = '0;
		last_idx = 2'd0;
		is_eos = 1'b0;
		unique case (q_head.kind)
			KIND_EOS: begin
				is_eos = 1'b1;
			end
			KIND_TO_UTF16: begin
				if (cp <= BMP_MAX) begin
					unit0 = cp[15:0];
				end else begin
					unit0 = SURR_HIGH_BASE | UNIT_W'(supp_off[21:10]);
					unit1 = SURR_LOW_BASE | UNIT_W'(supp_off[9:0]);
					last_idx = 2'd1;
				end
			end
			KIND_TO_UTF8: begin
				priority if (cp <= ONE_BYTE_MAX) begin
					unit0 = UNIT_W'(cp[6:0]);
				end else if (cp <= TWO_BYTE_MAX) begin
					unit0 = UNIT_W'({3'b110, cp[10:6]});
					unit1 = UNIT_W'({2'b10, cp[5:0]});
					last_idx = 2'd1;
				end else if (cp <= BMP_MAX) begin
					unit0 = UNIT_W'({4'b1110, cp[15:12]});
					unit1 = UNIT_W'({2'b10, cp[11:6]});
					unit2 = UNIT_W'({2'b10, cp[5:0]});
					last_idx = 2'd2;
				end else begin
					unit0 = UNIT_W'({4'b1111, cp[21:18]});
					unit1 = UNIT_W'({2'b10, cp[17:12]});
					unit2 = UNIT_W'({2'b10, cp[11:6]});
					unit3 = UNIT_W'({2'b10, cp[5:0]});
					last_idx = 2'd3;
				end
			end
			default: begin
				is_eos = 1'b0;
			end
		endcase
	end

	always_comb begin
		unique case (idx_q)
			2'd0: out_unit = unit0;
			2'd1: out_unit = unit1;
			2'd2: out_unit = unit2;
			2'd3: out_unit = unit3;
			default: out_unit = unit0;
		endcase
	end

	assign empty = q_empty;
	assign last_of_run = (idx_q == last_idx);
	assign end_of_string = is_eos;
	assign beat = pop && !q_empty;
	assign q_pop = beat && last_of_run;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (beat) begin
			idx_q <= last_of_run ? 2'd0 : idx_q + 2'd1;
		end
	end

	`ASSERT_IMPLIES(a_idx_in_run, clk, arst_n, !q_empty, idx_q <= last_idx)
	`ASSERT_IMPLIES(a_idx_idle, clk, arst_n, q_empty, idx_q == 2'd0)
	`ASSERT_IMPLIES(a_eos_alone, clk, arst_n, !q_empty && end_of_string,
		last_of_run && out_unit == '0)

endmodule

[tb/tb_utf8_utf16_transcoder_top.sv]
`timescale 1ns / 1ps

module tb_utf8_utf16_transcoder_top;
	import utx_pkg::*;

	typedef enum logic {
		DIR_8TO16 = 1'b0,
		DIR_16TO8 = 1'b1
	} dir_t;

	typedef enum int {
		RX_STREAM,
		RX_COIN,
		RX_SPARSE,
		RX_PERIODIC
	} rx_mode_t;

	typedef struct packed {
		logic [UNIT_W-1:0] unit;
		logic last;
		logic eos;
	} beat_t;

	logic clk;
	logic arst_n;
	logic cfg_valid;
	logic cfg_ready;
	logic cfg_data;
	logic push;
	logic full;
	logic [UNIT_W-1:0] code_unit;
	logic pop;
	logic empty;
	logic [UNIT_W-1:0] out_unit;
	logic last_of_run;
	logic end_of_string;

	dir_t dir_model;
	logic [CP_W-1:0] acc;
	logic [CNT_W-1:0] seq_need;
	logic [CNT_W-1:0] seq_seen;
	beat_t run_beats[$];
	beat_t awaited_units[$];
	beat_t want;

	int error_count = 0;
	int units_sent = 0;
	int beats_checked = 0;
	int dir_writes = 0;
	int burst_left = 0;
	rx_mode_t rx_mode = RX_STREAM;
	int rx_left = 0;

	utf8_utf16_transcoder_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.push(push),
		.full(full),
		.code_unit(code_unit),
		.pop(pop),
		.empty(empty),
		.out_unit(out_unit),
		.last_of_run(last_of_run),
		.end_of_string(end_of_string)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	task automatic report_error(input string msg);
		if (error_count < 40)
			$display("ERROR at %0t ns: %s", $time, msg);
		error_count++;
	endtask

	task automatic clear_model();
		acc = '0;
		seq_need = '0;
		seq_seen = '0;
	endtask

	task automatic add_beat(input logic [UNIT_W-1:0] unit, input logic eos);
		beat_t nb;
		nb.unit = unit;
		nb.last = 1'b0;
		nb.eos = eos;
		run_beats.push_back(nb);
	endtask

	task automatic emit_utf16(input logic [CP_W-1:0] cp);
		logic [CP_W-1:0] v;
		if (cp <= BMP_MAX) begin
			add_beat(cp[15:0], 1'b0);
		end else begin
			v = cp - SUPP_BASE;
			add_beat({4'd0, v[21:10]} | SURR_HIGH_BASE, 1'b0);
			add_beat({6'd0, v[9:0]} | SURR_LOW_BASE, 1'b0);
		end
	endtask

	task automatic emit_utf8(input logic [CP_W-1:0] cp);
		if (cp <= ONE_BYTE_MAX) begin
			add_beat({9'd0, cp[6:0]}, 1'b0);
		end else if (cp <= TWO_BYTE_MAX) begin
			add_beat({8'd0, 3'b110, cp[10:6]}, 1'b0);
			add_beat({8'd0, 2'b10, cp[5:0]}, 1'b0);
		end else if (cp <= BMP_MAX) begin
			add_beat({8'd0, 4'b1110, cp[15:12]}, 1'b0);
			add_beat({8'd0, 2'b10, cp[11:6]}, 1'b0);
			add_beat({8'd0, 2'b10, cp[5:0]}, 1'b0);
		end else begin
			add_beat({8'd0, 4'b1111, cp[21:18]}, 1'b0);
			add_beat({8'd0, 2'b10, cp[17:12]}, 1'b0);
			add_beat({8'd0, 2'b10, cp[11:6]}, 1'b0);
			add_beat({8'd0, 2'b10, cp[5:0]}, 1'b0);
		end
	endtask

	task automatic predict_transcode(input logic [UNIT_W-1:0] unit);
		logic [7:0] b;
		b = unit[7:0];
		run_beats.delete();
		if (dir_model == DIR_8TO16) begin
			if (seq_need == 0) begin
				if (b == 8'h00) begin
					add_beat('0, 1'b1);
				end else if (!b[7]) begin
					emit_utf16({14'd0, b});
				end else begin
					if (!b[5]) begin
						seq_need = 3'd2;
						acc = {16'd0, b[5:0]};
					end else if (!b[4]) begin
						seq_need = 3'd3;
						acc = {17'd0, b[4:0]};
					end else begin
						seq_need = 3'd4;
						acc = {18'd0, b[3:0]};
					end
					seq_seen = 3'd1;
				end
			end else begin
				acc = {acc[15:0], b[5:0]};
				seq_seen = seq_seen + 3'd1;
				if (seq_seen >= seq_need) begin
					emit_utf16(acc);
					clear_model();
				end
			end
		end else begin
			if (seq_need == 0) begin
				if (unit == '0) begin
					add_beat('0, 1'b1);
				end else if (unit >= SURR_FIRST && unit <= SURR_LAST) begin
					acc = {6'd0, unit};
					seq_need = 3'd2;
					seq_seen = 3'd1;
				end else begin
					emit_utf8({6'd0, unit});
				end
			end else begin
				emit_utf8({2'd0, acc[9:0], unit[9:0]} + SUPP_BASE);
				clear_model();
			end
		end
		if (run_beats.size() != 0) begin
			run_beats[run_beats.size() - 1].last = 1'b1;
			foreach (run_beats[i])
				awaited_units.push_back(run_beats[i]);
		end
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (pop && !empty) begin
				if (awaited_units.size() == 0) begin
					report_error($sformatf("unexpected beat out_unit=%h", out_unit));
				end else begin
					want = awaited_units.pop_front();
					if (out_unit !== want.unit)
						report_error($sformatf("out_unit %h, expected %h", out_unit, want.unit));
					if (last_of_run !== want.last)
						report_error($sformatf("last_of_run %b, expected %b on unit %h",
							last_of_run, want.last, want.unit));
					if (end_of_string !== want.eos)
						report_error($sformatf("end_of_string %b, expected %b on unit %h",
							end_of_string, want.eos, want.unit));
					beats_checked++;
				end
			end
			if (cfg_valid && cfg_ready) begin
				dir_model = dir_t'(cfg_data);
				clear_model();
			end
			if (push && !full)
				predict_transcode(code_unit);
		end
	end

	initial pop = 1'b0;
	always @(negedge clk) begin
		if (rx_left == 0) begin
			rx_mode = rx_mode_t'($urandom_range(0, 3));
			rx_left = $urandom_range(16, 96);
		end else begin
			rx_left--;
		end
		case (rx_mode)
			RX_STREAM: pop <= 1'b1;
			RX_COIN: pop <= 1'($urandom_range(0, 1));
			RX_SPARSE: pop <= ($urandom_range(0, 3) == 0);
			default: pop <= (rx_left % 5 != 0);
		endcase
	end

	task automatic send_unit(input logic [UNIT_W-1:0] value);
		int gap;
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
			gap = $urandom_range(0, 6);
			if (gap != 0) begin
				@(negedge clk);
				push <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		@(negedge clk);
		push <= 1'b1;
		code_unit <= value;
		do @(posedge clk); while (full);
		burst_left--;
		units_sent++;
	endtask

	task automatic wait_drained();
		int waited;
		waited = 0;
		@(negedge clk);
		push <= 1'b0;
		while (awaited_units.size() != 0 && waited < 4000) begin
			@(posedge clk);
			waited++;
		end
		if (awaited_units.size() != 0) begin
			report_error($sformatf("%0d result beats never arrived", awaited_units.size()));
			awaited_units.delete();
		end
	endtask

	// A unit that only opens a sequence yields no beat, so give it time to settle.
	task automatic write_direction(input dir_t d);
		wait_drained();
		repeat (8) @(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= d;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
		dir_writes++;
	endtask

	task automatic test_utf8_directed();
		logic [UNIT_W-1:0] seq[$];
		seq = '{16'h0041, 16'h007F, 16'hFF41, 16'h00C3, 16'h00A9, 16'h0080, 16'h0000,
			16'h00DF, 16'hFFBF, 16'h00E2, 16'h0082, 16'h00AC, 16'h00F0, 16'h009F,
			16'h0098, 16'h0080, 16'h00FF, 16'h00FF, 16'h00FF, 16'h00FF, 16'h0000};
		foreach (seq[i])
			send_unit(seq[i]);
		wait_drained();
	endtask

	task automatic test_utf16_directed();
		logic [UNIT_W-1:0] seq[$];
		seq = '{16'h0041, 16'h007F, 16'h0080, 16'h07FF, 16'h0800, 16'hFFFF, 16'hD83D,
			16'hDE00, 16'hDBFF, 16'hDFFF, 16'hDC00, 16'h0000, 16'hD800, 16'hFFFF,
			16'hE000, 16'h0000};
		write_direction(DIR_16TO8);
		foreach (seq[i])
			send_unit(seq[i]);
		wait_drained();
	endtask

	task automatic test_abandoned_sequence();
		write_direction(DIR_16TO8);
		send_unit(16'hD800);
		write_direction(DIR_16TO8);
		send_unit(16'h0041);
		write_direction(DIR_8TO16);
		send_unit(16'h00E2);
		send_unit(16'h0082);
		write_direction(DIR_8TO16);
		send_unit(16'h0041);
		send_unit(16'h00F4);
		write_direction(DIR_16TO8);
		send_unit(16'hDC01);
		send_unit(16'h0000);
		wait_drained();
	endtask

	task automatic random_utf8_phase(input int count);
		int stop_at;
		int pick;
		int len;
		logic [7:0] lead;
		stop_at = units_sent + count;
		while (units_sent < stop_at) begin
			pick = $urandom_range(0, 99);
			if (pick < 70) begin
				len = $urandom_range(1, 4);
				case (len)
					1: lead = 8'($urandom_range(1, 127));
					2: lead = 8'($urandom_range(128, 223));
					3: lead = 8'($urandom_range(224, 239));
					default: lead = 8'($urandom_range(240, 255));
				endcase
				send_unit({8'($urandom), lead});
				repeat (len - 1)
					send_unit({8'($urandom), 2'b10, 6'($urandom)});
			end else if (pick < 75) begin
				send_unit({8'($urandom), 8'h00});
			end else begin
				send_unit(16'($urandom));
			end
		end
	endtask

	task automatic random_utf16_phase(input int count);
		int stop_at;
		int pick;
		stop_at = units_sent + count;
		while (units_sent < stop_at) begin
			pick = $urandom_range(0, 99);
			if (pick < 45) begin
				send_unit({6'b110110, 10'($urandom)});
				send_unit({6'b110111, 10'($urandom)});
			end else if (pick < 75) begin
				case ($urandom_range(0, 3))
					0: send_unit(16'($urandom_range(1, 16'h007F)));
					1: send_unit(16'($urandom_range(16'h0080, 16'h07FF)));
					2: send_unit(16'($urandom_range(16'h0800, 16'hD7FF)));
					default: send_unit(16'($urandom_range(16'hE000, 16'hFFFF)));
				endcase
			end else if (pick < 80) begin
				send_unit(16'h0000);
			end else begin
				send_unit(16'($urandom));
			end
		end
	endtask

	task automatic test_random_streams();
		write_direction(DIR_8TO16);
		random_utf8_phase(36);
		write_direction(DIR_16TO8);
		random_utf16_phase(36);
		write_direction(DIR_8TO16);
		random_utf8_phase(36);
		write_direction(DIR_16TO8);
		random_utf16_phase(36);
		write_direction(DIR_16TO8);
		random_utf16_phase(36);
		write_direction(DIR_8TO16);
		random_utf8_phase(36);
		wait_drained();
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = 1'b0;
		push = 1'b0;
		code_unit = '0;
		dir_model = DIR_8TO16;
		clear_model();
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		test_utf8_directed();
		test_utf16_directed();
		test_abandoned_sequence();
		test_random_streams();
		repeat (20) @(posedge clk);
		$display("Sent %0d code units over %0d direction writes; checked %0d result beats.",
			units_sent, dir_writes, beats_checked);
		$display("Covered all lead classes, surrogate pairs, terminators, dropped sequences and noise.");
		if (error_count == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

	initial begin
		#2000000;
		$display("TEST FAILED");
		$finish;
	end

endmodule
